>>> design/sioc_pkg.sv
// shared types and constants of the scaled image over checker compositor
`default_nettype none

package sioc_pkg;

   // default raster store geometry
   localparam int RASTER_COLS_DEF = 256;
   localparam int RASTER_ROWS_DEF = 256;

   // field and register widths
   localparam int COORD_W     = 12;
   localparam int PIXEL_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int FIX_W       = 24;
   localparam int SIZE_W      = 9;
   localparam int WIN_W       = 13;

   // register reset values
   localparam logic [SIZE_W-1:0] RASTER_SIZE_RESET   = 9'd1;
   localparam logic [FIX_W-1:0]  OFFSET_RESET        = 24'd0;
   localparam logic [FIX_W-1:0]  SCALE_RESET         = 24'd65536;
   localparam logic [WIN_W-1:0]  WINDOW_HEIGHT_RESET = 13'd1;

   // checkerboard gray levels and the opaque and clear alpha bytes
   localparam logic [7:0] CHECK_LIGHT_LEVEL = 8'hCC;
   localparam logic [7:0] CHECK_DARK_LEVEL  = 8'h99;
   localparam logic [7:0] ALPHA_OPAQUE      = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR       = 8'h00;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RASTER_WIDTH  = 3'd0,
      CSR_RASTER_HEIGHT = 3'd1,
      CSR_OFFSET_X      = 3'd2,
      CSR_OFFSET_Y      = 3'd3,
      CSR_SCALE_X       = 3'd4,
      CSR_SCALE_Y       = 3'd5,
      CSR_WINDOW_HEIGHT = 3'd6
   } csr_index_type;

   typedef struct packed {
      op_type               operation;
      logic [COORD_W-1:0]   x_coord;
      logic [COORD_W-1:0]   y_coord;
      logic [PIXEL_W-1:0]   pixel_rgba;
   } req_type;

   typedef struct packed {
      logic [PIXEL_W-1:0]   color;
      logic [COORD_W-1:0]   out_col;
      logic [COORD_W-1:0]   out_row;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/sioc_ram.sv
// generic single-port ram with registered read
`default_nettype none

module sioc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one access per cycle, read data held while disabled
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

>>> design/scaled_image_over_checker_compositor_core.sv
// top level of the scaled image over checker compositor
//
// req channel: valid/ready transactions; a load writes pixel_rgba into the raster
// store at (x_coord, y_coord), a render asks for one screen pixel at (x_coord, y_coord).
// rsp channel: one transaction per render with the opaque color 0xFFRRGGBB, the
// screen column and the bottom-up row; loads produce nothing.
// csr channel: register writes by index, always ready; write only while idle.
// pipeline: input capture with offset subtract, scale multiply, a retiming stage,
// bounds check and store read, blend multiply, blend divide into the output register.
// path: a render passes stage registers s1 to s5, then the output register.
// throughput: one transaction per cycle unless a held rsp stalls the pipeline,
// loads and renders mixed; the single store port serves one write or one read in
// each cycle, both at the same stage, so accesses keep transaction order.
// stall: each stage holds while the one after it is full and held, bubbles
// collapse, and req_ready drops only when every stage is occupied.
// reset: clears all valid bits and restores the register defaults; the raster
// store has no reset and must be loaded before it is sampled.
`default_nettype none

module scaled_image_over_checker_compositor_core #(
   parameter int RASTER_COLS = sioc_pkg::RASTER_COLS_DEF,
   parameter int RASTER_ROWS = sioc_pkg::RASTER_ROWS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire sioc_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output sioc_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [sioc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sioc_pkg::CSR_DATA_W-1:0]  csr_data
);

   import sioc_pkg::*;

   localparam int DEPTH  = RASTER_COLS * RASTER_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (RASTER_COLS > 1) ? $clog2(RASTER_COLS) : 1;
   localparam int ROW_W  = (RASTER_ROWS > 1) ? $clog2(RASTER_ROWS) : 1;
   localparam logic [FIX_W-1:0] COLS_FIX = FIX_W'(RASTER_COLS);
   localparam logic [FIX_W-1:0] ROWS_FIX = FIX_W'(RASTER_ROWS);

   // exact divide by 255 for values up to 255 * 255
   function automatic logic [7:0] div255(input logic [16:0] v);
      logic [16:0] t;
      t = v + 17'd1 + (v >> 8);
      return t[15:8];
   endfunction

   // configuration registers
   logic [SIZE_W-1:0] raster_width_ff;
   logic [SIZE_W-1:0] raster_height_ff;
   logic [FIX_W-1:0]  offset_x_ff;
   logic [FIX_W-1:0]  offset_y_ff;
   logic [FIX_W-1:0]  scale_x_ff;
   logic [FIX_W-1:0]  scale_y_ff;
   logic [WIN_W-1:0]  window_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raster_width_ff  <= RASTER_SIZE_RESET;
         raster_height_ff <= RASTER_SIZE_RESET;
         offset_x_ff      <= OFFSET_RESET;
         offset_y_ff      <= OFFSET_RESET;
         scale_x_ff       <= SCALE_RESET;
         scale_y_ff       <= SCALE_RESET;
         window_height_ff <= WINDOW_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_RASTER_WIDTH:  raster_width_ff  <= csr_data[SIZE_W-1:0];
            CSR_RASTER_HEIGHT: raster_height_ff <= csr_data[SIZE_W-1:0];
            CSR_OFFSET_X:      offset_x_ff      <= csr_data;
            CSR_OFFSET_Y:      offset_y_ff      <= csr_data;
            CSR_SCALE_X:       scale_x_ff       <= csr_data;
            CSR_SCALE_Y:       scale_y_ff       <= csr_data;
            CSR_WINDOW_HEIGHT: window_height_ff <= csr_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // stage valid bits and per-stage load enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic rsp_valid_ff;
   logic ld1, ld2, ld3, ld4, ld5, ld_out;

   assign ld_out    = !rsp_valid_ff || rsp_ready;
   assign ld5       = !s5_valid_ff || ld_out;
   assign ld4       = !s4_valid_ff || ld5;
   assign ld3       = !s3_valid_ff || ld4;
   assign ld2       = !s2_valid_ff || ld3;
   assign ld1       = !s1_valid_ff || ld2;
   assign req_ready = ld1;

   // stage 1: coordinate minus offset as sign and magnitude, checker and row flip
   logic signed [FIX_W:0] dpos_x_in, dneg_x_in, dpos_y_in, dneg_y_in;
   logic [COORD_W-1:0]    out_row_in;

   assign dpos_x_in = $signed({5'b0, req_data.x_coord, 8'b0})
                      - $signed({offset_x_ff[FIX_W-1], offset_x_ff});
   assign dneg_x_in = $signed({offset_x_ff[FIX_W-1], offset_x_ff})
                      - $signed({5'b0, req_data.x_coord, 8'b0});
   assign dpos_y_in = $signed({5'b0, req_data.y_coord, 8'b0})
                      - $signed({offset_y_ff[FIX_W-1], offset_y_ff});
   assign dneg_y_in = $signed({offset_y_ff[FIX_W-1], offset_y_ff})
                      - $signed({5'b0, req_data.y_coord, 8'b0});
   assign out_row_in = window_height_ff[COORD_W-1:0] - COORD_W'(1) - req_data.y_coord;

   op_type             s1_op_ff;
   logic [COORD_W-1:0] s1_x_ff, s1_y_ff, s1_row_ff;
   logic [PIXEL_W-1:0] s1_pix_ff;
   logic               s1_neg_x_ff, s1_neg_y_ff, s1_dark_ff;
   logic [FIX_W-1:0]   s1_mag_x_ff, s1_mag_y_ff;

   always_ff @(posedge clock) begin
      if (ld1) begin
         s1_op_ff    <= req_data.operation;
         s1_x_ff     <= req_data.x_coord;
         s1_y_ff     <= req_data.y_coord;
         s1_pix_ff   <= req_data.pixel_rgba;
         s1_row_ff   <= out_row_in;
         s1_dark_ff  <= req_data.x_coord[4] ^ req_data.y_coord[4];
         s1_neg_x_ff <= dpos_x_in[FIX_W];
         s1_neg_y_ff <= dpos_y_in[FIX_W];
         s1_mag_x_ff <= dpos_x_in[FIX_W] ? dneg_x_in[FIX_W-1:0] : dpos_x_in[FIX_W-1:0];
         s1_mag_y_ff <= dpos_y_in[FIX_W] ? dneg_y_in[FIX_W-1:0] : dpos_y_in[FIX_W-1:0];
      end
   end

   // stage 2: magnitude times scale, keep the integer part
   logic [2*FIX_W-1:0] prod_x_in, prod_y_in;

   assign prod_x_in = s1_mag_x_ff * scale_x_ff;
   assign prod_y_in = s1_mag_y_ff * scale_y_ff;

   op_type             s2_op_ff;
   logic [COORD_W-1:0] s2_x_ff, s2_y_ff, s2_row_ff;
   logic [PIXEL_W-1:0] s2_pix_ff;
   logic               s2_neg_x_ff, s2_neg_y_ff, s2_dark_ff;
   logic [FIX_W-1:0]   s2_q_x_ff, s2_q_y_ff;

   always_ff @(posedge clock) begin
      if (ld2) begin
         s2_op_ff    <= s1_op_ff;
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_pix_ff   <= s1_pix_ff;
         s2_row_ff   <= s1_row_ff;
         s2_dark_ff  <= s1_dark_ff;
         s2_neg_x_ff <= s1_neg_x_ff;
         s2_neg_y_ff <= s1_neg_y_ff;
         s2_q_x_ff   <= prod_x_in[2*FIX_W-1:FIX_W];
         s2_q_y_ff   <= prod_y_in[2*FIX_W-1:FIX_W];
      end
   end

   // stage 3 registers
   op_type             s3_op_ff;
   logic [COORD_W-1:0] s3_x_ff, s3_y_ff, s3_row_ff;
   logic [PIXEL_W-1:0] s3_pix_ff;
   logic               s3_neg_x_ff, s3_neg_y_ff, s3_dark_ff;
   logic [FIX_W-1:0]   s3_q_x_ff, s3_q_y_ff;

   always_ff @(posedge clock) begin
      if (ld3) begin
         s3_op_ff    <= s2_op_ff;
         s3_x_ff     <= s2_x_ff;
         s3_y_ff     <= s2_y_ff;
         s3_pix_ff   <= s2_pix_ff;
         s3_row_ff   <= s2_row_ff;
         s3_dark_ff  <= s2_dark_ff;
         s3_neg_x_ff <= s2_neg_x_ff;
         s3_neg_y_ff <= s2_neg_y_ff;
         s3_q_x_ff   <= s2_q_x_ff;
         s3_q_y_ff   <= s2_q_y_ff;
      end
   end

   // stage 3 logic: bounds checks and store address, loads and reads share the port
   logic [FIX_W-1:0]  lim_x, lim_y, x_ext, y_ext;
   logic              inb_x, inb_y, load_inb, render_inb_in;
   logic [COL_W-1:0]  col_idx;
   logic [ROW_W-1:0]  row_idx;
   logic [ADDR_W-1:0] ram_addr;
   logic              ram_we;
   logic [PIXEL_W-1:0] ram_rdata;

   assign lim_x = (FIX_W'(raster_width_ff) < COLS_FIX) ? FIX_W'(raster_width_ff) : COLS_FIX;
   assign lim_y = (FIX_W'(raster_height_ff) < ROWS_FIX) ? FIX_W'(raster_height_ff) : ROWS_FIX;
   // a small negative mapping truncates to zero and is still sampled
   assign inb_x = s3_neg_x_ff ? (s3_q_x_ff == '0) : (s3_q_x_ff < lim_x);
   assign inb_y = s3_neg_y_ff ? (s3_q_y_ff == '0) : (s3_q_y_ff < lim_y);
   assign render_inb_in = inb_x && inb_y;

   assign x_ext    = FIX_W'(s3_x_ff);
   assign y_ext    = FIX_W'(s3_y_ff);
   assign load_inb = (x_ext < COLS_FIX) && (y_ext < ROWS_FIX);

   assign col_idx  = (s3_op_ff == OP_LOAD) ? x_ext[COL_W-1:0] : s3_q_x_ff[COL_W-1:0];
   assign row_idx  = (s3_op_ff == OP_LOAD) ? y_ext[ROW_W-1:0] : s3_q_y_ff[ROW_W-1:0];
   assign ram_addr = ADDR_W'(32'(row_idx) * 32'(RASTER_COLS) + 32'(col_idx));
   assign ram_we   = s3_valid_ff && (s3_op_ff == OP_LOAD) && load_inb;

   sioc_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_raster (
      .clock (clock),
      .en    (ld4),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (s3_pix_ff),
      .rdata (ram_rdata)
   );

   // stage 4: store read data arrives, only renders continue
   logic               s4_inb_ff, s4_dark_ff;
   logic [COORD_W-1:0] s4_x_ff, s4_row_ff;

   always_ff @(posedge clock) begin
      if (ld4) begin
         s4_inb_ff  <= render_inb_in;
         s4_dark_ff <= s3_dark_ff;
         s4_x_ff    <= s3_x_ff;
         s4_row_ff  <= s3_row_ff;
      end
   end

   // stage 4 logic: blend products per channel
   logic [PIXEL_W-1:0] sample;
   logic [7:0]         alpha, bg_level, inv_alpha;
   logic [15:0]        fr_in, fg_in, fb_in, br_in, bg_in, bb_in;

   assign sample    = s4_inb_ff ? ram_rdata : '0;
   assign alpha     = sample[31:24];
   assign inv_alpha = ALPHA_OPAQUE - alpha;
   assign bg_level  = s4_dark_ff ? CHECK_DARK_LEVEL : CHECK_LIGHT_LEVEL;
   assign fr_in     = sample[7:0] * alpha;
   assign fg_in     = sample[15:8] * alpha;
   assign fb_in     = sample[23:16] * alpha;
   assign br_in     = bg_level * inv_alpha;
   assign bg_in     = bg_level * inv_alpha;
   assign bb_in     = bg_level * inv_alpha;

   logic [15:0]        s5_fr_ff, s5_fg_ff, s5_fb_ff, s5_br_ff, s5_bg_ff, s5_bb_ff;
   logic [23:0]        s5_rgb_ff;
   logic               s5_full_ff, s5_clear_ff;
   logic [7:0]         s5_bg_level_ff;
   logic [COORD_W-1:0] s5_x_ff, s5_row_ff;

   always_ff @(posedge clock) begin
      if (ld5) begin
         s5_fr_ff       <= fr_in;
         s5_fg_ff       <= fg_in;
         s5_fb_ff       <= fb_in;
         s5_br_ff       <= br_in;
         s5_bg_ff       <= bg_in;
         s5_bb_ff       <= bb_in;
         s5_rgb_ff      <= {sample[7:0], sample[15:8], sample[23:16]};
         s5_full_ff     <= (alpha == ALPHA_OPAQUE);
         s5_clear_ff    <= (alpha == ALPHA_CLEAR);
         s5_bg_level_ff <= bg_level;
         s5_x_ff        <= s4_x_ff;
         s5_row_ff      <= s4_row_ff;
      end
   end

   // stage 5 logic: sum, divide by 255, pick the case for the alpha value
   logic [7:0]         mix_r, mix_g, mix_b;
   logic [PIXEL_W-1:0] color_in;

   assign mix_r = div255(17'(s5_fr_ff) + 17'(s5_br_ff));
   assign mix_g = div255(17'(s5_fg_ff) + 17'(s5_bg_ff));
   assign mix_b = div255(17'(s5_fb_ff) + 17'(s5_bb_ff));

   always_comb begin
      priority if (s5_full_ff) begin
         color_in = {ALPHA_OPAQUE, s5_rgb_ff};
      end else if (s5_clear_ff) begin
         color_in = {ALPHA_OPAQUE, s5_bg_level_ff, s5_bg_level_ff, s5_bg_level_ff};
      end else begin
         color_in = {ALPHA_OPAQUE, mix_r, mix_g, mix_b};
      end
   end

   // output register
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (ld_out) begin
         rsp_data_ff.color   <= color_in;
         rsp_data_ff.out_col <= s5_x_ff;
         rsp_data_ff.out_row <= s5_row_ff;
      end
   end

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld1) begin
            s1_valid_ff <= req_valid;
         end
         if (ld2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (ld3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (ld4) begin
            s4_valid_ff <= s3_valid_ff && (s3_op_ff == OP_RENDER);
         end
         if (ld5) begin
            s5_valid_ff <= s4_valid_ff;
         end
         if (ld_out) begin
            rsp_valid_ff <= s5_valid_ff;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
